// ===== rtl/core/epi_pkg.sv =====
package epi_pkg;

  localparam int unsigned AngW = 16;
  localparam int unsigned DurW = 16;
  localparam logic [AngW-1:0] AngFull = 16'd46080;
  localparam logic [AngW-1:0] AngHalf = 16'd23040;

  typedef enum logic {
    REQ_SET   = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DELTA,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } back_state_e;

  function automatic logic [AngW-1:0] ang_reduce(input logic [AngW-1:0] a);
    ang_reduce = (a >= AngFull) ? AngW'(a - AngFull) : a;
  endfunction

endpackage

// ===== rtl/core/epi_front.sv =====
module epi_front #(
  parameter int unsigned PosW = 32,
  parameter int unsigned TimeW = 48
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    in_type_i,
  input  logic [TimeW-1:0]        in_now_i,
  input  logic [3*PosW-1:0]       in_pos_i,
  input  logic [3*16-1:0]         in_ang_i,
  output logic                    q_valid_o,
  input  logic                    q_ready_i,
  output logic                    q_type_o,
  output logic [TimeW-1:0]        q_now_o,
  output logic [3*PosW-1:0]       q_pos_o,
  output logic [3*16-1:0]         q_ang_o
);
  import epi_pkg::*;

  // Two-entry queue between the front and the back.
  logic [1:0] cnt_q, cnt_d;
  logic       wr_q, wr_d, rd_q, rd_d;
  logic       ty_q [2];
  logic [TimeW-1:0] now_q [2];
  logic [3*PosW-1:0] pos_q [2];
  logic [3*16-1:0] ang_q [2];
  logic push, pop;
  logic [3*16-1:0] ang_red;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ang_red[i*16 +: 16] = ang_reduce(in_ang_i[i*16 +: 16]);
    end
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop = q_valid_o && q_ready_i;
  assign q_type_o = ty_q[rd_q];
  assign q_now_o = now_q[rd_q];
  assign q_pos_o = pos_q[rd_q];
  assign q_ang_o = ang_q[rd_q];

  always_comb begin
    cnt_d = cnt_q + 2'(push) - 2'(pop);
    wr_d = push ? ~wr_q : wr_q;
    rd_d = pop ? ~rd_q : rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q <= 1'b0;
      rd_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      wr_q <= wr_d;
      rd_q <= rd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ty_q[wr_q] <= in_type_i;
      now_q[wr_q] <= in_now_i;
      pos_q[wr_q] <= in_pos_i;
      ang_q[wr_q] <= ang_red;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !pop) |=> (cnt_q == 2'd2)) else $error("full queue lost an entry");

endmodule

// ===== rtl/core/epi_back.sv =====
module epi_back #(
  parameter int unsigned PosW = 32,
  parameter int unsigned TimeW = 48,
  parameter int unsigned FracW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [15:0]          dur_i,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  logic                 q_type_i,
  input  logic [TimeW-1:0]     q_now_i,
  input  logic [3*PosW-1:0]    q_pos_i,
  input  logic [3*16-1:0]      q_ang_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic                 res_known_o,
  output logic [3*PosW-1:0]    res_pos_o,
  output logic [3*16-1:0]      res_ang_o,
  output logic [TimeW-1:0]     res_stamp_o
);
  import epi_pkg::*;

  localparam int unsigned CntW = $clog2(FracW + 1);
  localparam int unsigned DW = PosW + 1;
  localparam int unsigned TW = FracW + 1;
  localparam int unsigned PW = DW + TW;

  back_state_e st_q, st_d;
  logic known_q;
  logic signed [PosW-1:0] prev_p_q [3], goal_p_q [3];
  logic [15:0] prev_a_q [3], goal_a_q [3];
  logic [TimeW-1:0] start_q;
  logic ty_q;
  logic [TimeW-1:0] now_q;
  logic [3*PosW-1:0] np_q;
  logic [3*16-1:0] na_q;
  logic [TW-1:0] t_q;
  logic [16:0] rem_q;
  logic [FracW-1:0] quo_q;
  logic [CntW-1:0] cnt_q;
  logic signed [DW-1:0] del_q [6];
  logic signed [PW-1:0] prod_q [6];
  logic out_v_q;
  logic [3*PosW-1:0] out_p_q;
  logic [3*16-1:0] out_a_q;
  logic [TimeW-1:0] out_s_q;
  logic out_k_q;

  logic [TimeW-1:0] el;
  logic [17:0] rem_sh;
  logic take;
  logic signed [PosW-1:0] sum_p [3];
  logic [15:0] sum_a [3];

  assign q_ready_o = (st_q == ST_IDLE);
  assign take = q_valid_i && q_ready_o;
  assign el = q_now_i - start_q;
  assign rem_sh = {rem_q, 1'b0};

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (take) st_d = ST_DIV;
      ST_DIV: if (cnt_q == '0) st_d = ST_DELTA;
      ST_DELTA: st_d = ST_MUL;
      ST_MUL: st_d = ST_SUM;
      ST_SUM: st_d = ST_DONE;
      ST_DONE: if (!out_v_q || res_ready_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [PosW:0] s;
      logic signed [17:0] a;
      s = DW'($signed({prev_p_q[i][PosW-1], prev_p_q[i]}) + (prod_q[i] >>> FracW));
      sum_p[i] = s[PosW-1:0];
      a = $signed({2'b00, prev_a_q[i]}) + 18'((prod_q[i+3] >>> FracW));
      if (a < 0) a = a + $signed({2'b00, AngFull});
      else if (a >= $signed({2'b00, AngFull})) a = a - $signed({2'b00, AngFull});
      sum_a[i] = a[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      known_q <= 1'b0;
      start_q <= '0;
      out_v_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev_p_q[i] <= '0;
        goal_p_q[i] <= '0;
        prev_a_q[i] <= '0;
        goal_a_q[i] <= '0;
      end
    end else begin
      st_q <= st_d;
      if (out_v_q && res_ready_i) out_v_q <= 1'b0;
      if (st_q == ST_SUM) begin
        if (ty_q == REQ_QUERY) begin
          out_v_q <= 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            prev_p_q[i] <= known_q ? sum_p[i] : np_q[i*PosW +: PosW];
            prev_a_q[i] <= known_q ? sum_a[i] : na_q[i*16 +: 16];
            goal_p_q[i] <= np_q[i*PosW +: PosW];
            goal_a_q[i] <= na_q[i*16 +: 16];
          end
          known_q <= 1'b1;
          start_q <= now_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        ty_q <= q_type_i;
        now_q <= q_now_i;
        np_q <= q_pos_i;
        na_q <= q_ang_i;
        rem_q <= {1'b0, el[15:0]};
        quo_q <= '0;
        cnt_q <= CntW'(FracW);
        if (dur_i == '0) t_q <= TW'(1) << FracW;
        else if (q_now_i < start_q) t_q <= '0;
        else if (el >= TimeW'(dur_i)) t_q <= TW'(1) << FracW;
        else t_q <= '1;
      end
      ST_DIV: begin
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - CntW'(1);
          if (rem_sh >= {2'b00, dur_i}) begin
            rem_q <= 17'(rem_sh - {2'b00, dur_i});
            quo_q <= {quo_q[FracW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh[16:0];
            quo_q <= {quo_q[FracW-2:0], 1'b0};
          end
        end else if (t_q == '1) begin
          t_q <= {1'b0, quo_q};
        end
      end
      ST_DELTA: begin
        for (int i = 0; i < 3; i++) begin
          logic [16:0] d;
          del_q[i] <= $signed({goal_p_q[i][PosW-1], goal_p_q[i]})
                    - $signed({prev_p_q[i][PosW-1], prev_p_q[i]});
          d = {1'b0, goal_a_q[i]} + {1'b0, AngFull} - {1'b0, prev_a_q[i]}
            + {1'b0, AngHalf};
          if (d >= {1'b0, AngFull}) d = d - {1'b0, AngFull};
          if (d >= {1'b0, AngFull}) d = d - {1'b0, AngFull};
          del_q[i+3] <= DW'($signed({1'b0, d}) - $signed({2'b00, AngHalf}));
        end
      end
      ST_MUL: begin
        for (int i = 0; i < 6; i++) begin
          prod_q[i] <= PW'(del_q[i]) * $signed({1'b0, t_q});
        end
      end
      ST_SUM: begin
        out_k_q <= known_q;
        out_s_q <= known_q ? now_q : '0;
        for (int i = 0; i < 3; i++) begin
          out_p_q[i*PosW +: PosW] <= known_q ? sum_p[i] : '0;
          out_a_q[i*16 +: 16] <= known_q ? sum_a[i] : '0;
        end
      end
      default: ;
    endcase
  end

  assign res_valid_o = out_v_q;
  assign res_known_o = out_k_q;
  assign res_pos_o = out_p_q;
  assign res_ang_o = out_a_q;
  assign res_stamp_o = out_s_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> !q_ready_o) else $error("ready while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DONE && out_v_q && !res_ready_i) |=> (st_q == ST_DONE))
    else $error("left done with result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(known_q) |-> 1'b0) else $error("target flag cleared");

endmodule

// ===== rtl/core/entity_pose_interpolator_unit.sv =====
// Channel   | Dir | Beat contents
// s_axis    | in  | tuser=req_type; tdata=now_ms,pos_x,pos_y,pos_z,pitch,yaw,roll
// m_axis    | out | tuser=valid_pose; tdata=x,y,z,pitch,yaw,roll,stamp_ms
// apb       | in  | blend_duration_ms at address 0
// The radix-2 divider of the blend fraction gives one bit per cycle over
// FRACTION_BITS; the back end takes no new item until the last is done.
// A two-beat queue lets the input side take beats while the back end works.
// Reset is asynchronous and active low; it clears the pose state and sets
// the duration to 100 ms. A stalled result holds the back end.
module entity_pose_interpolator_unit #(
  parameter int unsigned POS_WIDTH = 32,
  parameter int unsigned TIME_WIDTH = 48,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // now_ms, pos_x, pos_y, pos_z, pitch_in, yaw_in, roll_in
  input  logic [((TIME_WIDTH+3*POS_WIDTH+48+7)/8)*8-1:0] s_axis_tdata,
  // req_type
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // out_x, out_y, out_z, out_pitch, out_yaw, out_roll, stamp_ms
  output logic [((TIME_WIDTH+3*POS_WIDTH+48+7)/8)*8-1:0] m_axis_tdata,
  // valid_pose
  output logic m_axis_tuser,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import epi_pkg::*;

  localparam int unsigned DataW = ((TIME_WIDTH + 3*POS_WIDTH + 48 + 7) / 8) * 8;
  localparam int unsigned UsedW = TIME_WIDTH + 3*POS_WIDTH + 48;

  logic [15:0] dur_q;
  logic q_valid, q_ready, q_type;
  logic [TIME_WIDTH-1:0] q_now, r_stamp;
  logic [3*POS_WIDTH-1:0] q_pos, r_pos;
  logic [47:0] q_ang, r_ang;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'd0, dur_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q <= 16'd100;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      dur_q <= pwdata[15:0];
    end
  end

  epi_front #(.PosW(POS_WIDTH), .TimeW(TIME_WIDTH)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_type_i(s_axis_tuser),
    .in_now_i(s_axis_tdata[TIME_WIDTH-1:0]),
    .in_pos_i(s_axis_tdata[TIME_WIDTH +: 3*POS_WIDTH]),
    .in_ang_i(s_axis_tdata[TIME_WIDTH+3*POS_WIDTH +: 48]),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_type_o(q_type),
    .q_now_o(q_now), .q_pos_o(q_pos), .q_ang_o(q_ang)
  );

  epi_back #(.PosW(POS_WIDTH), .TimeW(TIME_WIDTH), .FracW(FRACTION_BITS)) u_back (
    .clk_i, .rst_ni, .dur_i(dur_q),
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_type_i(q_type),
    .q_now_i(q_now), .q_pos_i(q_pos), .q_ang_i(q_ang),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_known_o(m_axis_tuser), .res_pos_o(r_pos), .res_ang_o(r_ang),
    .res_stamp_o(r_stamp)
  );

  assign m_axis_tdata = DataW'({r_stamp, r_ang, r_pos});

  if (DataW > UsedW) begin : g_pad
    logic unused_pad;
    assign unused_pad = ^s_axis_tdata[DataW-1:UsedW];
  end

endmodule

// ===== test/tb_entity_pose_interpolator_unit.sv =====
`timescale 1ns / 100ps

module tb_entity_pose_interpolator_unit;
  import epi_pkg::*;

  localparam int unsigned DataW = 192;
  localparam longint unsigned TimeMax = 64'hFFFF_FFFF_FFFF;
  localparam longint AngTurn = 46080;
  localparam longint AngHalfTurn = 23040;
  localparam longint TOne = 65536;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [1:0] AddrDuration = 2'd0;

  typedef struct {
    logic valid;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [15:0] pitch;
    logic [15:0] yaw;
    logic [15:0] roll;
    logic [47:0] stamp;
  } pose_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [DataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [DataW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  entity_pose_interpolator_unit i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the interpolator state.
  longint unsigned duration_ms = 100;
  logic target_known = 1'b0;
  longint prev_pos[3];
  longint goal_pos[3];
  longint prev_ang[3];
  longint goal_ang[3];
  longint unsigned start_ms = 0;

  pose_t pending_poses[$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned n_sets = 0;
  int unsigned n_queries = 0;
  int unsigned n_checked = 0;
  bit idle_on = 1'b1;

  function automatic longint blend_fraction(longint unsigned now);
    longint unsigned el;
    if (duration_ms == 0) return TOne;
    if (now < start_ms) return 0;
    el = now - start_ms;
    if (el >= duration_ms) return TOne;
    return longint'((el << 16) / duration_ms);
  endfunction

  function automatic longint lerp_pos(longint from, longint to, longint t);
    return from + (((to - from) * t) >>> 16);
  endfunction

  function automatic longint lerp_ang(longint from, longint to, longint t);
    longint d;
    longint r;
    d = ((to + AngTurn - from + AngHalfTurn) % AngTurn) - AngHalfTurn;
    r = from + ((d * t) >>> 16);
    if (r < 0) r += AngTurn;
    if (r >= AngTurn) r -= AngTurn;
    return r;
  endfunction

  task automatic blended_pose(input longint unsigned now, output longint p[3],
                              output longint a[3]);
    longint t;
    t = blend_fraction(now);
    for (int i = 0; i < 3; i++) begin
      p[i] = lerp_pos(prev_pos[i], goal_pos[i], t);
      a[i] = lerp_ang(prev_ang[i], goal_ang[i], t);
    end
  endtask

  task automatic predict_pose(input req_e req, input logic [DataW-1:0] d);
    longint unsigned now;
    longint np[3];
    longint na[3];
    longint p[3];
    longint a[3];
    pose_t e;
    now = d[47:0];
    if (req == REQ_SET) begin
      n_sets++;
      for (int i = 0; i < 3; i++) begin
        np[i] = longint'($signed(d[48+32*i +: 32]));
        na[i] = longint'(d[144+16*i +: 16]) % AngTurn;
      end
      if (target_known) begin
        blended_pose(now, p, a);
        prev_pos = p;
        prev_ang = a;
      end else begin
        prev_pos = np;
        prev_ang = na;
        target_known = 1'b1;
      end
      goal_pos = np;
      goal_ang = na;
      start_ms = now;
    end else begin
      n_queries++;
      e = '{1'b0, '0, '0, '0, '0, '0, '0, '0};
      if (target_known) begin
        blended_pose(now, p, a);
        e = '{1'b1, p[0][31:0], p[1][31:0], p[2][31:0], a[0][15:0], a[1][15:0],
              a[2][15:0], now[47:0]};
      end
      pending_poses.push_back(e);
    end
  endtask

  task automatic send_item(input req_e req, input longint unsigned now, input logic [31:0] x,
                           input logic [31:0] y, input logic [31:0] z,
                           input logic [15:0] pitch, input logic [15:0] yaw,
                           input logic [15:0] roll);
    logic [DataW-1:0] d;
    d = {roll, yaw, pitch, z, y, x, now[47:0]};
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pose(req, d);
    if (idle_on && $urandom_range(99) < 36) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_duration(input logic [15:0] value);
    drain_results();
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= AddrDuration;
    pwdata <= {16'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    duration_ms = value;
  endtask

  function automatic logic [15:0] rand_angle();
    return ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                     : 16'($urandom_range(46079));
  endfunction

  function automatic logic [31:0] rand_pos();
    return ($urandom_range(3) == 0) ? 32'($signed($urandom_range(4000)) - 2000) << 12
                                    : $urandom;
  endfunction

  task automatic send_random_set(input longint unsigned now);
    send_item(REQ_SET, now, rand_pos(), rand_pos(), rand_pos(), rand_angle(), rand_angle(),
              rand_angle());
  endtask

  task automatic send_query(input longint unsigned now);
    send_item(REQ_QUERY, now, $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
              16'($urandom));
  endtask

  task automatic test_query_before_target();
    send_query(64'd12345);
    send_query(TimeMax);
  endtask

  task automatic test_directed_extremes();
    send_item(REQ_SET, 1000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'd0, 16'd46079,
              16'd65535);
    send_query(1000);
    send_item(REQ_SET, 1000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'd46079, 16'd0,
              16'd46080);
    send_query(1050);
    send_query(999);
    send_query(1099);
    send_query(1100);
    send_item(REQ_SET, 1070, 32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678, 16'd23040,
              16'd23040, 16'd100);
    send_query(1080);
    send_query(TimeMax);
    send_item(REQ_SET, TimeMax - 30, 32'h0, 32'h0, 32'h0, 16'd11520, 16'd34560, 16'd23039);
    send_query(TimeMax);
    send_query(0);
    send_item(REQ_SET, 0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 16'hAAAA, 16'h5555,
              16'hB3FF);
    send_query(33);
  endtask

  task automatic run_blend_sequences(input int unsigned n_items);
    longint unsigned base;
    longint unsigned span;
    int unsigned sent;
    sent = 0;
    base = {$urandom, $urandom} & TimeMax;
    while (sent < n_items) begin
      if ($urandom_range(19) == 0) base = {$urandom, $urandom} & TimeMax;
      if (base > TimeMax - 200000) base = base - 200000;
      span = duration_ms + duration_ms / 4 + 2;
      base = base + $urandom_range(span);
      send_random_set(base);
      sent++;
      repeat ($urandom_range(1, 5)) begin
        case ($urandom_range(9))
          0: send_query(base - $urandom_range(1, 50));
          1: send_query({$urandom, $urandom} & TimeMax);
          default: send_query(base + $urandom_range(span));
        endcase
        sent++;
      end
    end
  endtask

  task automatic test_duration_sweep();
    logic [15:0] settings[5];
    settings = '{16'd0, 16'd1, 16'd65535, 16'd100, 16'($urandom_range(2, 5000))};
    foreach (settings[i]) begin
      write_duration(settings[i]);
      run_blend_sequences(40);
    end
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      write_duration((phase == 3) ? 16'($urandom) : 16'($urandom_range(1, 3000)));
      idle_on = (phase != 2);
      run_blend_sequences(150);
    end
    idle_on = 1'b1;
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_poses.size() == 0) begin
        $display("%0t: unexpected result beat, actual user=%0b data=%h", $time, m_axis_tuser,
                 m_axis_tdata);
        errors++;
      end else begin
        pose_t e;
        pose_t a;
        e = pending_poses.pop_front();
        a = '{m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tdata[95:64],
              m_axis_tdata[111:96], m_axis_tdata[127:112], m_axis_tdata[143:128],
              m_axis_tdata[191:144]};
        n_checked++;
        if (a.valid !== e.valid) begin
          $display("%0t: valid_pose expected %0b actual %0b", $time, e.valid, a.valid);
          errors++;
        end
        if (a.x !== e.x) begin
          $display("%0t: out_x expected %h actual %h", $time, e.x, a.x);
          errors++;
        end
        if (a.y !== e.y) begin
          $display("%0t: out_y expected %h actual %h", $time, e.y, a.y);
          errors++;
        end
        if (a.z !== e.z) begin
          $display("%0t: out_z expected %h actual %h", $time, e.z, a.z);
          errors++;
        end
        if (a.pitch !== e.pitch) begin
          $display("%0t: out_pitch expected %0d actual %0d", $time, e.pitch, a.pitch);
          errors++;
        end
        if (a.yaw !== e.yaw) begin
          $display("%0t: out_yaw expected %0d actual %0d", $time, e.yaw, a.yaw);
          errors++;
        end
        if (a.roll !== e.roll) begin
          $display("%0t: out_roll expected %0d actual %0d", $time, e.roll, a.roll);
          errors++;
        end
        if (a.stamp !== e.stamp) begin
          $display("%0t: stamp_ms expected %h actual %h", $time, e.stamp, a.stamp);
          errors++;
        end
      end
    end
    m_axis_tready <= !(idle_on && $urandom_range(99) < 36);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               pending_poses.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 3; i++) begin
      prev_pos[i] = 0;
      goal_pos[i] = 0;
      prev_ang[i] = 0;
      goal_ang[i] = 0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_query_before_target();
    test_directed_extremes();
    test_duration_sweep();
    test_random_traffic();
    drain_results();
    $display("Sent %0d set-target and %0d query beats; %0d results were compared.", n_sets,
             n_queries, n_checked);
    $display("Durations covered zero, one, the maximum, the reset value and random values.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
